FILE: rtl/core/psg_pkg.sv
`default_nettype none

package psg_pkg;

  // Width of the completed-sweeps result field
  localparam int SWEEPS_W = 32;

  // Width of the configuration register index
  localparam int CFG_IDX_W = 2;

  // Configuration register reset values
  localparam int RST_FROM   = 0;
  localparam int RST_TO     = 100;
  localparam int RST_STEP   = 1;
  localparam bit RST_BOUNCE = 1'b0;

  // Direction command codes carried with each input beat
  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_FWD    = 2'd1,
    DIR_REV    = 2'd2,
    DIR_TOGGLE = 2'd3
  } dir_cmd_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FROM   = 2'd0,
    CFG_TO     = 2'd1,
    CFG_STEP   = 2'd2,
    CFG_BOUNCE = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/core/position_sweep_generator_top.sv
`default_nettype none

// Position sweep generator: sawtooth (wrap) or triangle (bounce) position sweep.
// Input channel (in_valid / in_stall) carries one beat per step request:
// advance, restart and a direction command. Each accepted beat yields exactly
// one result beat on the output channel (out_valid / out_stall) with the new
// position, the direction and the number of completed sweeps.
// The result of an accepted beat is loaded into the output register at the
// accepting edge. Throughput is one beat per cycle while out_stall is low; the
// single update path (an add and a subtract, bound compares and a select on the
// registered position) sets that rate.
// in_stall is high only while a result is held and out_stall is high, so a
// waiting result blocks further beats until taken and nothing is dropped.
// Configuration writes (cfg_valid / cfg_ready) are always taken; bounds, step
// and mode act at once, position and direction reload only on restart.
// Synchronous reset (rst_n low) loads the default configuration, performs the
// start-up sequence and empties the output register.
module position_sweep_generator_top #(
  parameter int POS_WIDTH   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  psg_pkg::cfg_reg_t              cfg_index,
  input  wire  [POS_WIDTH-1:0]                 cfg_data,
  // Input channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_advance,
  input  wire                                  in_restart,
  input  wire  psg_pkg::dir_cmd_t              in_dir_command,
  // Output channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [POS_WIDTH:0]            out_position,
  output logic                                 out_moving_forward,
  output logic [psg_pkg::SWEEPS_W-1:0]         out_sweeps_done
);

  import psg_pkg::*;

  localparam int PW   = POS_WIDTH + 1;   // position width
  localparam int EW   = POS_WIDTH + 2;   // working width for step arithmetic
  localparam int SW   = POS_WIDTH - 1;   // step width

  localparam logic signed [EW-1:0] POS_MAX_E = {2'b00, {POS_WIDTH{1'b1}}};
  localparam logic signed [EW-1:0] POS_MIN_E = {2'b11, {POS_WIDTH{1'b0}}};

  localparam bit                   RST_DIR = (RST_FROM < RST_TO);
  localparam logic signed [PW-1:0] RST_POS = RST_DIR ? PW'(RST_FROM - RST_STEP)
                                                     : PW'(RST_FROM + RST_STEP);

  // Configuration registers
  logic signed [POS_WIDTH-1:0] cfg_from_r;
  logic signed [POS_WIDTH-1:0] cfg_to_r;
  logic        [SW-1:0]        cfg_step_r;
  logic                        cfg_bounce_r;

  // Sweep state
  logic signed [PW-1:0]        pos_r,  pos_nxt;
  logic                        dir_r,  dir_nxt;
  logic [COUNT_WIDTH-1:0]      hits_r, hits_nxt;

  // Output register
  logic                        out_valid_r;
  logic signed [PW-1:0]        out_pos_r;
  logic                        out_dir_r;
  logic [SWEEPS_W-1:0]         out_done_r;

  logic                        in_take;
  logic                        cfg_take;

  // Working values
  logic signed [EW-1:0]        from_e, to_e, lo_e, hi_e, step_e, pos_e;
  logic signed [EW-1:0]        pos_plus, pos_minus, start_e, step_res;
  logic                        fwd_cfg, dir_mid, dir_step, hit;
  logic [COUNT_WIDTH-1:0]      done_full;
  logic [SWEEPS_W-1:0]         done_out;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    if (v > POS_MAX_E) begin
      c = POS_MAX_E;
    end else if (v < POS_MIN_E) begin
      c = POS_MIN_E;
    end else begin
      c = v;
    end
    return c[PW-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;

  // Accept a beat whenever the output register is empty or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  // Extend configuration and state into the working width
  always_comb begin
    from_e    = {{2{cfg_from_r[POS_WIDTH-1]}}, cfg_from_r};
    to_e      = {{2{cfg_to_r[POS_WIDTH-1]}}, cfg_to_r};
    step_e    = {{(EW-SW){1'b0}}, cfg_step_r};
    pos_e     = {pos_r[PW-1], pos_r};
    fwd_cfg   = (cfg_from_r < cfg_to_r);
    lo_e      = fwd_cfg ? from_e : to_e;
    hi_e      = fwd_cfg ? to_e : from_e;
    pos_plus  = pos_e + step_e;
    pos_minus = pos_e - step_e;
    start_e   = fwd_cfg ? (from_e - step_e) : (from_e + step_e);
  end

  // Apply the direction command, then take one step
  always_comb begin
    case (in_dir_command)
      DIR_NONE:   dir_mid = dir_r;
      DIR_FWD:    dir_mid = 1'b1;
      DIR_REV:    dir_mid = 1'b0;
      DIR_TOGGLE: dir_mid = ~dir_r;
      default:    dir_mid = dir_r;
    endcase

    dir_step = dir_mid;
    hit      = 1'b0;
    step_res = pos_e;
    if (!cfg_bounce_r) begin
      // Wrap: jump to the opposite bound once past a bound
      if (dir_mid) begin
        if (pos_plus > hi_e) begin
          step_res = lo_e;
          hit      = 1'b1;
        end else begin
          step_res = pos_plus;
        end
      end else begin
        if (pos_minus < lo_e) begin
          step_res = hi_e;
          hit      = 1'b1;
        end else begin
          step_res = pos_minus;
        end
      end
    end else begin
      // Bounce: turn around at or beyond a bound and step back
      if (dir_mid) begin
        if (pos_e < hi_e) begin
          step_res = pos_plus;
        end else begin
          step_res = pos_minus;
          dir_step = 1'b0;
          hit      = 1'b1;
        end
      end else begin
        if (pos_e > lo_e) begin
          step_res = pos_minus;
        end else begin
          step_res = pos_plus;
          dir_step = 1'b1;
          hit      = 1'b1;
        end
      end
    end
  end

  // Next sweep state for the beat being accepted
  always_comb begin
    pos_nxt  = pos_r;
    dir_nxt  = dir_r;
    hits_nxt = hits_r;
    if (in_take) begin
      if (in_restart) begin
        pos_nxt  = sat_pos(start_e);
        dir_nxt  = fwd_cfg;
        hits_nxt = '0;
      end else if (in_advance) begin
        pos_nxt  = sat_pos(step_res);
        dir_nxt  = dir_step;
        hits_nxt = hits_r + (hit ? COUNT_WIDTH'(1) : COUNT_WIDTH'(0));
      end else begin
        dir_nxt  = dir_mid;
      end
    end
  end

  // Completed sweeps: hit count, halved in bounce mode
  assign done_full = cfg_bounce_r ? (hits_nxt >> 1) : hits_nxt;

  generate
    if (COUNT_WIDTH >= SWEEPS_W) begin : g_done_trunc
      assign done_out = done_full[SWEEPS_W-1:0];
    end else begin : g_done_ext
      assign done_out = {{(SWEEPS_W-COUNT_WIDTH){1'b0}}, done_full};
    end
  endgenerate

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_from_r   <= POS_WIDTH'(RST_FROM);
      cfg_to_r     <= POS_WIDTH'(RST_TO);
      cfg_step_r   <= SW'(RST_STEP);
      cfg_bounce_r <= RST_BOUNCE;
    end else if (cfg_take) begin
      case (cfg_index)
        CFG_FROM:   cfg_from_r   <= cfg_data;
        CFG_TO:     cfg_to_r     <= cfg_data;
        CFG_STEP:   cfg_step_r   <= cfg_data[SW-1:0];
        CFG_BOUNCE: cfg_bounce_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Sweep state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= RST_POS;
      dir_r  <= RST_DIR;
      hits_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      dir_r  <= dir_nxt;
      hits_r <= hits_nxt;
    end
  end

  // Output register: load on accept, drop when taken, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_pos_r  <= pos_nxt;
      out_dir_r  <= dir_nxt;
      out_done_r <= done_out;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = out_pos_r;
  assign out_moving_forward = out_dir_r;
  assign out_sweeps_done    = out_done_r;

endmodule

`default_nettype wire

FILE: rtl/core/psg_checker.sv
`default_nettype none

module psg_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              cfg_valid,
  input wire                              cfg_ready,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              in_restart,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [psg_pkg::SWEEPS_W-1:0]      out_sweeps_done
);

  // A stalled result beat stays on the channel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Every accepted beat shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // An empty output register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // A restart beat clears the sweep count
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_restart |=> out_sweeps_done == '0)
    else $error("restart did not clear the sweep count");

  // Configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind position_sweep_generator_top psg_checker u_psg_checker (.*);

`default_nettype wire

FILE: dv/position_sweep_generator_top_tb.sv
`default_nettype none

module position_sweep_generator_top_tb;
  import psg_pkg::*;

  localparam int POS_W       = 16;
  localparam int POS_HI      = 2 ** POS_W - 1;
  localparam int POS_LO      = -(2 ** POS_W);
  localparam int QUIET_LIMIT = 500;
  localparam int RANDOM_BEATS = 1470;
  localparam int CALM_BEATS  = 160;

  typedef struct packed {
    logic signed [POS_W:0] position;
    logic                  moving_forward;
    logic [SWEEPS_W-1:0]   sweeps_done;
  } sweep_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = CFG_FROM;
  logic [POS_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_advance = 1'b0;
  logic                  in_restart = 1'b0;
  dir_cmd_t              in_dir_command = DIR_NONE;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [POS_W:0] out_position;
  logic                  out_moving_forward;
  logic [SWEEPS_W-1:0]   out_sweeps_done;

  // Shadow configuration and sweep state
  logic signed [POS_W-1:0] sh_from;
  logic signed [POS_W-1:0] sh_to;
  logic [POS_W-2:0]        sh_step;
  logic                    sh_bounce;
  int                      sh_pos;
  logic                    sh_fwd;
  logic [SWEEPS_W-1:0]     sh_hits;

  sweep_result_t pending_sweeps[$];
  int            mismatch_count = 0;
  int            beats_sent = 0;
  int            quiet_cycles = 0;
  bit            idle_on = 1'b1;
  int            stall_left = 0;

  position_sweep_generator_top #(
    .POS_WIDTH  (POS_W),
    .COUNT_WIDTH(32)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_advance        (in_advance),
    .in_restart        (in_restart),
    .in_dir_command    (in_dir_command),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_moving_forward(out_moving_forward),
    .out_sweeps_done   (out_sweeps_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_position(input int v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // Reload direction, position and hit count from the live configuration
  task automatic sweep_start_up();
    int f;
    int t;
    int s;
    f = sh_from;
    t = sh_to;
    s = sh_step;
    sh_fwd  = (f < t);
    sh_pos  = clamp_position(sh_fwd ? f - s : f + s);
    sh_hits = '0;
  endtask

  // Move one step, wrapping or bouncing at the bounds
  task automatic sweep_advance();
    int  f;
    int  t;
    int  lo;
    int  hi;
    int  s;
    int  p;
    bit  hit;
    f   = sh_from;
    t   = sh_to;
    lo  = (f < t) ? f : t;
    hi  = (f < t) ? t : f;
    s   = sh_step;
    p   = sh_pos;
    hit = 1'b0;
    if (!sh_bounce) begin
      if (sh_fwd) begin
        p = p + s;
        if (p > hi) begin
          p   = lo;
          hit = 1'b1;
        end
      end else begin
        p = p - s;
        if (p < lo) begin
          p   = hi;
          hit = 1'b1;
        end
      end
    end else begin
      if (sh_fwd) begin
        if (p < hi) begin
          p = p + s;
        end else begin
          sh_fwd = 1'b0;
          p      = p - s;
          hit    = 1'b1;
        end
      end else begin
        if (p > lo) begin
          p = p - s;
        end else begin
          sh_fwd = 1'b1;
          p      = p + s;
          hit    = 1'b1;
        end
      end
    end
    sh_pos = clamp_position(p);
    if (hit) sh_hits = sh_hits + 1'b1;
  endtask

  // Apply one accepted beat and queue the result it should produce
  task automatic predict_sweep(input bit adv, input bit rst, input dir_cmd_t cmd);
    sweep_result_t r;
    if (rst) begin
      sweep_start_up();
    end else begin
      case (cmd)
        DIR_FWD:    sh_fwd = 1'b1;
        DIR_REV:    sh_fwd = 1'b0;
        DIR_TOGGLE: sh_fwd = ~sh_fwd;
        default:    ;
      endcase
      if (adv) sweep_advance();
    end
    r.position       = sh_pos[POS_W:0];
    r.moving_forward = sh_fwd;
    r.sweeps_done    = sh_bounce ? (sh_hits >> 1) : sh_hits;
    pending_sweeps.push_back(r);
  endtask

  // Drive one beat, with an optional gap, and hold it until accepted
  task automatic send_beat(input bit adv, input bit rst, input dir_cmd_t cmd);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_advance     <= adv;
    in_restart     <= rst;
    in_dir_command <= cmd;
    do @(posedge clk); while (in_stall);
    predict_sweep(adv, rst, cmd);
    beats_sent++;
  endtask

  task automatic send_random_beat();
    dir_cmd_t cmd;
    cmd = ($urandom_range(0, 7) < 5) ? DIR_NONE : dir_cmd_t'($urandom_range(0, 3));
    send_beat($urandom_range(0, 9) != 0, $urandom_range(0, 49) == 0, cmd);
  endtask

  // Drop valid and wait for every queued result to drain
  task automatic wait_sweeps_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sweeps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FROM:   sh_from   = data;
      CFG_TO:     sh_to     = data;
      CFG_STEP:   sh_step   = data[POS_W-2:0];
      CFG_BOUNCE: sh_bounce = data[0];
      default:    ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_bound();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return POS_W'($urandom_range(0, 120) - 60);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        default: return 16'h7FFE;
      endcase
    end
    return POS_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return POS_W'($urandom_range(0, 9));
    if (r == 7) return {$urandom_range(0, 1) == 1, 15'd0};
    if (r == 8) return {$urandom_range(0, 1) == 1, 15'h7FFF};
    return POS_W'($urandom);
  endfunction

  // Rewrite all or a random subset of registers while idle, optionally restart
  task automatic reconfigure_sweep(input bit write_all);
    if (write_all || $urandom_range(0, 3) != 0) write_reg(CFG_FROM, pick_bound());
    if (write_all || $urandom_range(0, 3) != 0) write_reg(CFG_TO, pick_bound());
    if (write_all || $urandom_range(0, 3) != 0) write_reg(CFG_STEP, pick_step());
    if (write_all || $urandom_range(0, 3) != 0) begin
      write_reg(CFG_BOUNCE, POS_W'($urandom));
    end
    if ($urandom_range(0, 1) == 1) begin
      send_beat($urandom_range(0, 1) == 1, 1'b1, dir_cmd_t'($urandom_range(0, 3)));
    end
  endtask

  // Direction commands and restart at the reset configuration
  task automatic test_direction_commands();
    send_beat(1'b1, 1'b0, DIR_NONE);
    send_beat(1'b0, 1'b0, DIR_REV);
    send_beat(1'b1, 1'b0, DIR_NONE);
    send_beat(1'b1, 1'b0, DIR_TOGGLE);
    send_beat(1'b1, 1'b0, DIR_FWD);
    send_beat(1'b0, 1'b0, DIR_TOGGLE);
    send_beat(1'b1, 1'b1, DIR_TOGGLE);
    send_beat(1'b1, 1'b0, DIR_NONE);
  endtask

  // Full-range bounds with the largest step, wrap then live switch to bounce
  task automatic test_extreme_bounds();
    wait_sweeps_drained();
    write_reg(CFG_FROM, 16'h8000);
    write_reg(CFG_TO, 16'h7FFF);
    write_reg(CFG_STEP, 16'hFFFF);
    write_reg(CFG_BOUNCE, 16'h0000);
    send_beat(1'b0, 1'b1, DIR_NONE);
    repeat (4) send_beat(1'b1, 1'b0, DIR_NONE);
    send_beat(1'b1, 1'b0, DIR_TOGGLE);
    wait_sweeps_drained();
    write_reg(CFG_BOUNCE, 16'hFFFF);
    repeat (3) send_beat(1'b1, 1'b0, DIR_NONE);
    wait_sweeps_drained();
    write_reg(CFG_FROM, 16'h7FFF);
    write_reg(CFG_TO, 16'h8000);
    send_beat(1'b0, 1'b1, DIR_NONE);
    send_beat(1'b1, 1'b0, DIR_NONE);
  endtask

  // Equal bounds and a zero step: position holds, hits still count in bounce mode
  task automatic test_equal_bounds_zero_step();
    wait_sweeps_drained();
    write_reg(CFG_FROM, 16'd5);
    write_reg(CFG_TO, 16'd5);
    write_reg(CFG_STEP, 16'd0);
    send_beat(1'b1, 1'b1, DIR_FWD);
    repeat (3) send_beat(1'b1, 1'b0, DIR_NONE);
    wait_sweeps_drained();
    write_reg(CFG_BOUNCE, 16'd0);
    send_beat(1'b1, 1'b0, DIR_NONE);
    send_beat(1'b1, 1'b0, DIR_TOGGLE);
  endtask

  // Random phases, each under its own configuration
  task automatic test_random_sweeps();
    int phase;
    int len;
    phase = 0;
    while (beats_sent < RANDOM_BEATS) begin
      wait_sweeps_drained();
      idle_on = ($urandom_range(0, 3) != 0);
      reconfigure_sweep(phase == 0);
      len = $urandom_range(40, 120);
      for (int i = 0; i < len; i++) begin
        // hold off the sender once until everything has come back
        if (phase == 2 && i == len / 2) wait_sweeps_drained();
        send_random_beat();
      end
      phase++;
    end
  endtask

  // Closing stretch with no gaps or stalls
  task automatic test_back_to_back();
    wait_sweeps_drained();
    idle_on = 1'b0;
    reconfigure_sweep(1'b1);
    repeat (CALM_BEATS) send_random_beat();
  endtask

  // Random stall bursts on the result side
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    sweep_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sweeps.size() == 0) begin
        $display("%0t: unexpected result beat position %0d forward %0b sweeps %0d",
                 $time, out_position, out_moving_forward, out_sweeps_done);
        mismatch_count++;
      end else begin
        exp_r = pending_sweeps.pop_front();
        if (out_position !== exp_r.position) begin
          $display("%0t: position expected %0d actual %0d",
                   $time, exp_r.position, out_position);
          mismatch_count++;
        end
        if (out_moving_forward !== exp_r.moving_forward) begin
          $display("%0t: moving_forward expected %0b actual %0b",
                   $time, exp_r.moving_forward, out_moving_forward);
          mismatch_count++;
        end
        if (out_sweeps_done !== exp_r.sweeps_done) begin
          $display("%0t: sweeps_done expected %0d actual %0d",
                   $time, exp_r.sweeps_done, out_sweeps_done);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sh_from   = RST_FROM;
    sh_to     = RST_TO;
    sh_step   = RST_STEP;
    sh_bounce = RST_BOUNCE;
    sweep_start_up();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_direction_commands();
    test_extreme_bounds();
    test_equal_bounds_zero_step();
    test_random_sweeps();
    test_back_to_back();

    wait_sweeps_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
